// ===== src/cdss_pkg.sv =====
// shared types, constants and saturation helpers for the spring smoother
package cdss_pkg;

    localparam int HL_W    = 24;             // half-life register, unsigned Q8.16
    localparam int DT_W    = 16;             // frame time, unsigned Q0.16
    localparam int MUL_W   = 33;             // shared multiplier operand width
    localparam int PROD_W  = 2 * MUL_W;
    localparam int NUM_W   = 49;             // divider dividend width
    localparam int DEN_W   = 41;             // divider divisor width
    localparam int QUO_W   = 33;             // divider quotient width
    localparam int Z_W     = 25;             // clamped z
    localparam int Z2_W    = 33;
    localparam int Z3_W    = 41;

    localparam logic [HL_W-1:0]  HALFLIFE_RESET = 24'd13107;
    localparam logic [32:0]      LN2X2_Q32      = 33'd5954088944;
    localparam logic [NUM_W-1:0] E_NUM          = 49'h1_0000_0000_0000;
    localparam logic [DEN_W-1:0] ONE_Q16        = 41'd65536;
    localparam logic [Z_W-1:0]   Z_LIMIT        = 25'h100_0000;
    localparam logic [14:0]      C048_Q16       = 15'd31457;
    localparam logic [13:0]      C0235_Q16      = 14'd15401;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] goal;
        logic [DT_W-1:0]    time_step;
        logic signed [31:0] load_position;
        logic signed [31:0] load_velocity;
    } req_item_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
    } rsp_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_YDIV,
        ST_YD,
        ST_J0Y,
        ST_ZZ,
        ST_J1DT,
        ST_Z3,
        ST_Z2C,
        ST_J1YD,
        ST_Z3H,
        ST_Z3L,
        ST_DEN,
        ST_EGO,
        ST_EDIV,
        ST_TXE,
        ST_TVE,
        ST_VEL,
        ST_OUT
    } state_t;

    function automatic logic [31:0] abs32(input logic signed [31:0] a);
        return a[31] ? (32'd0 - $unsigned(a)) : $unsigned(a);
    endfunction

    // truncated magnitude given the operand sign, clamped to the signed 32-bit range
    function automatic logic signed [31:0] apply_sign(input logic neg, input logic [49:0] mag);
        logic signed [31:0] res;
        if (neg) begin
            if (mag >= 50'h8000_0000)
                res = 32'sh8000_0000;
            else
                res = $signed(32'd0 - mag[31:0]);
        end
        else begin
            if (mag >= 50'h7FFF_FFFF)
                res = 32'sh7FFF_FFFF;
            else
                res = $signed(mag[31:0]);
        end
        return res;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
        logic signed [31:0] res;
        if (s[32] != s[31])
            res = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            res = s[31:0];
        return res;
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat33(s);
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        return sat33(s);
    endfunction

endpackage

// ===== src/cdss_mul.sv =====
// shared unsigned multiplier with registered product
module cdss_mul (
    input  logic                           clk,
    input  logic [cdss_pkg::MUL_W-1:0]     a,
    input  logic [cdss_pkg::MUL_W-1:0]     b,
    output logic [cdss_pkg::PROD_W-1:0]    product
);

    logic [cdss_pkg::PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= a * b;
    end

    assign product = product_reg;

endmodule

// ===== src/cdss_div.sv =====
// restoring divider, one quotient bit per cycle, quotient known to fit QUO_W bits
module cdss_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cdss_pkg::NUM_W-1:0]    dividend,
    input  logic [cdss_pkg::DEN_W-1:0]    divisor,
    output logic                          done,
    output logic [cdss_pkg::QUO_W-1:0]    quotient
);

    localparam int DSH_W = cdss_pkg::DEN_W + cdss_pkg::QUO_W - 1;
    localparam int CNT_W = $clog2(cdss_pkg::QUO_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [cdss_pkg::NUM_W-1:0]  rem_reg;
    logic [DSH_W-1:0]            dsh_reg;
    logic [cdss_pkg::QUO_W-1:0]  q_reg;
    logic                        fits;

    assign fits = {{(DSH_W - cdss_pkg::NUM_W){1'b0}}, rem_reg} >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(cdss_pkg::QUO_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // divisor slides right one place per beat of the iteration
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsh_reg <= {divisor, {(cdss_pkg::QUO_W - 1){1'b0}}};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= rem_reg - dsh_reg[cdss_pkg::NUM_W-1:0];
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[cdss_pkg::QUO_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== src/critically_damped_spring_smoother_unit.sv =====
// top level: sequencer around one shared multiplier and one shared divider
//
// Spring smoother for one channel. A request beat carries an operation, a goal,
// a frame time and load values; every request gives exactly one response beat
// with the new position and velocity.
// Request channel: req_valid/req_stall/req_data, taken when valid and not stall.
// Response channel: rsp_valid/rsp_stall/rsp_data, held in an output register.
// Config channel: cfg_valid/cfg_ready/cfg_data writes the half-life; ready is
// always high and writes belong between requests.
// A load request goes straight to the output step, where its response is
// registered. A step request walks eleven multiplier beats and one division
// for the decay factor. The first step after reset or a half-life write also
// divides for the damping rate. The divider, at one bit per cycle, takes up
// most of a step. One request is in flight at a time; req_stall is high until
// the sequencer is back to idle.
// Reset clears position and velocity to zero and the half-life to 13107.
// A stalled response holds its register; the sequencer waits at its last step
// and the next request is taken once that beat leaves.
module critically_damped_spring_smoother_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  cdss_pkg::req_item_t           req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output cdss_pkg::rsp_item_t           rsp_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cdss_pkg::HL_W-1:0]     cfg_data
);

    cdss_pkg::state_t                 state_reg, state_next;

    logic [cdss_pkg::HL_W-1:0]        halflife_reg;
    logic                             y_valid_reg;
    logic signed [31:0]               cur_pos_reg;
    logic signed [31:0]               cur_vel_reg;
    logic                             rsp_valid_reg;
    cdss_pkg::rsp_item_t              rsp_reg;

    logic signed [31:0]               goal_reg;
    logic [cdss_pkg::DT_W-1:0]        dt_reg;
    logic signed [31:0]               j0_reg;
    logic signed [31:0]               j1_reg;
    logic signed [31:0]               tx_reg;
    logic signed [31:0]               tv_reg;
    logic [31:0]                      y_reg;
    logic [31:0]                      yd_reg;
    logic [cdss_pkg::Z_W-1:0]         zc_reg;
    logic [cdss_pkg::Z2_W-1:0]        z2_reg;
    logic [cdss_pkg::Z3_W-1:0]        z3_reg;
    logic [cdss_pkg::DEN_W-1:0]       den_reg;
    logic [cdss_pkg::QUO_W-1:0]       e_reg;

    logic                             req_fire;
    logic                             cfg_fire;
    logic                             rsp_free;
    logic                             div_start;
    logic                             div_done;
    logic [cdss_pkg::NUM_W-1:0]       div_num;
    logic [cdss_pkg::DEN_W-1:0]       div_den;
    logic [cdss_pkg::QUO_W-1:0]       div_q;
    logic [cdss_pkg::HL_W-1:0]        hl_eff;
    logic [cdss_pkg::MUL_W-1:0]       mul_a;
    logic [cdss_pkg::MUL_W-1:0]       mul_b;
    logic [cdss_pkg::PROD_W-1:0]      mul_p;
    logic [31:0]                      yd_new;

    assign req_stall = (state_reg != cdss_pkg::ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assign hl_eff  = (halflife_reg == '0) ? cdss_pkg::HL_W'(1) : halflife_reg;
    assign div_num = (state_reg == cdss_pkg::ST_EGO) ? cdss_pkg::E_NUM
                   : {{(cdss_pkg::NUM_W - 33){1'b0}}, cdss_pkg::LN2X2_Q32};
    assign div_den = (state_reg == cdss_pkg::ST_EGO) ? den_reg
                   : {{(cdss_pkg::DEN_W - cdss_pkg::HL_W){1'b0}}, hl_eff};
    assign yd_new  = mul_p[47:16];

    cdss_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    cdss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // each multiplier step issues one product; the product lands for the step after
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            cdss_pkg::ST_YD:
            begin
                mul_a = {1'b0, y_reg};
                mul_b = {17'b0, dt_reg};
            end
            cdss_pkg::ST_J0Y:
            begin
                mul_a = {1'b0, cdss_pkg::abs32(j0_reg)};
                mul_b = {1'b0, y_reg};
            end
            cdss_pkg::ST_ZZ:
            begin
                mul_a = {8'b0, zc_reg};
                mul_b = {8'b0, zc_reg};
            end
            cdss_pkg::ST_J1DT:
            begin
                mul_a = {1'b0, cdss_pkg::abs32(j1_reg)};
                mul_b = {17'b0, dt_reg};
            end
            cdss_pkg::ST_Z3:
            begin
                mul_a = z2_reg;
                mul_b = {8'b0, zc_reg};
            end
            cdss_pkg::ST_Z2C:
            begin
                mul_a = z2_reg;
                mul_b = {18'b0, cdss_pkg::C048_Q16};
            end
            cdss_pkg::ST_J1YD:
            begin
                mul_a = {1'b0, cdss_pkg::abs32(j1_reg)};
                mul_b = {1'b0, yd_reg};
            end
            cdss_pkg::ST_Z3H:
            begin
                mul_a = {8'b0, z3_reg[40:16]};
                mul_b = {19'b0, cdss_pkg::C0235_Q16};
            end
            cdss_pkg::ST_Z3L:
            begin
                mul_a = {17'b0, z3_reg[15:0]};
                mul_b = {19'b0, cdss_pkg::C0235_Q16};
            end
            cdss_pkg::ST_TXE:
            begin
                mul_a = {1'b0, cdss_pkg::abs32(tx_reg)};
                mul_b = e_reg;
            end
            cdss_pkg::ST_TVE:
            begin
                mul_a = {1'b0, cdss_pkg::abs32(tv_reg)};
                mul_b = e_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cdss_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            cdss_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req_data.operation == cdss_pkg::OP_LOAD)
                        state_next = cdss_pkg::ST_OUT;
                    else if (y_valid_reg)
                        state_next = cdss_pkg::ST_YD;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = cdss_pkg::ST_YDIV;
                    end
                end
            end
            cdss_pkg::ST_YDIV:
            begin
                if (div_done)
                    state_next = cdss_pkg::ST_YD;
            end
            cdss_pkg::ST_YD:   state_next = cdss_pkg::ST_J0Y;
            cdss_pkg::ST_J0Y:  state_next = cdss_pkg::ST_ZZ;
            cdss_pkg::ST_ZZ:   state_next = cdss_pkg::ST_J1DT;
            cdss_pkg::ST_J1DT: state_next = cdss_pkg::ST_Z3;
            cdss_pkg::ST_Z3:   state_next = cdss_pkg::ST_Z2C;
            cdss_pkg::ST_Z2C:  state_next = cdss_pkg::ST_J1YD;
            cdss_pkg::ST_J1YD: state_next = cdss_pkg::ST_Z3H;
            cdss_pkg::ST_Z3H:  state_next = cdss_pkg::ST_Z3L;
            cdss_pkg::ST_Z3L:  state_next = cdss_pkg::ST_DEN;
            cdss_pkg::ST_DEN:  state_next = cdss_pkg::ST_EGO;
            cdss_pkg::ST_EGO:
            begin
                div_start  = 1'b1;
                state_next = cdss_pkg::ST_EDIV;
            end
            cdss_pkg::ST_EDIV:
            begin
                if (div_done)
                    state_next = cdss_pkg::ST_TXE;
            end
            cdss_pkg::ST_TXE:  state_next = cdss_pkg::ST_TVE;
            cdss_pkg::ST_TVE:  state_next = cdss_pkg::ST_VEL;
            cdss_pkg::ST_VEL:  state_next = cdss_pkg::ST_OUT;
            cdss_pkg::ST_OUT:
            begin
                if (rsp_free)
                    state_next = cdss_pkg::ST_IDLE;
            end
            default:           state_next = cdss_pkg::ST_IDLE;
        endcase
    end

    // architectural state, config and response handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halflife_reg  <= cdss_pkg::HALFLIFE_RESET;
            y_valid_reg   <= 1'b0;
            cur_pos_reg   <= '0;
            cur_vel_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                halflife_reg <= cfg_data;
                y_valid_reg  <= 1'b0;
            end
            else if (state_reg == cdss_pkg::ST_YDIV && div_done)
                y_valid_reg <= 1'b1;

            if (req_fire && req_data.operation == cdss_pkg::OP_LOAD)
            begin
                cur_pos_reg <= req_data.load_position;
                cur_vel_reg <= req_data.load_velocity;
            end
            else if (state_reg == cdss_pkg::ST_TVE)
                cur_pos_reg <= cdss_pkg::add_sat(
                    cdss_pkg::apply_sign(tx_reg[31], {16'b0, mul_p[65:32]}), goal_reg);
            else if (state_reg == cdss_pkg::ST_VEL)
                cur_vel_reg <= cdss_pkg::apply_sign(tv_reg[31], {16'b0, mul_p[65:32]});

            if (state_reg == cdss_pkg::ST_OUT && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // working registers of one step
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            goal_reg <= req_data.goal;
            dt_reg   <= req_data.time_step;
            j0_reg   <= cdss_pkg::sub_sat(cur_pos_reg, req_data.goal);
        end

        if (state_reg == cdss_pkg::ST_YDIV && div_done)
            y_reg <= div_q[32] ? 32'hFFFF_FFFF : div_q[31:0];
        if (state_reg == cdss_pkg::ST_EDIV && div_done)
            e_reg <= div_q;

        case (state_reg)
            cdss_pkg::ST_J0Y:
            begin
                yd_reg <= yd_new;
                zc_reg <= (yd_new > 32'h0100_0000) ? cdss_pkg::Z_LIMIT : yd_new[24:0];
            end
            cdss_pkg::ST_ZZ:
            begin
                j1_reg  <= cdss_pkg::add_sat(cur_vel_reg,
                               cdss_pkg::apply_sign(j0_reg[31], mul_p[65:16]));
                den_reg <= cdss_pkg::ONE_Q16 + {16'b0, zc_reg};
            end
            cdss_pkg::ST_J1DT: z2_reg <= mul_p[48:16];
            cdss_pkg::ST_Z3:
                tx_reg <= cdss_pkg::add_sat(j0_reg,
                              cdss_pkg::apply_sign(j1_reg[31], mul_p[65:16]));
            cdss_pkg::ST_Z2C:  z3_reg <= mul_p[56:16];
            cdss_pkg::ST_J1YD: den_reg <= den_reg + mul_p[56:16];
            cdss_pkg::ST_Z3H:
                tv_reg <= cdss_pkg::sub_sat(cur_vel_reg,
                              cdss_pkg::apply_sign(j1_reg[31], mul_p[65:16]));
            // high half of z3 times 0.235 needs no shift, low half does
            cdss_pkg::ST_Z3L:  den_reg <= den_reg + mul_p[40:0];
            cdss_pkg::ST_DEN:  den_reg <= den_reg + mul_p[56:16];
            default:
            begin
            end
        endcase

        if (state_reg == cdss_pkg::ST_OUT && rsp_free)
        begin
            rsp_reg.position <= cur_pos_reg;
            rsp_reg.velocity <= cur_vel_reg;
        end
    end

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == cdss_pkg::ST_YDIV || state_reg == cdss_pkg::ST_EDIV))
        else $error("divider finished outside a division step");

    a_y_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cdss_pkg::ST_YD |-> y_valid_reg)
        else $error("step started without a damping rate");

    a_cfg_drops_y: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> !y_valid_reg)
        else $error("damping rate kept across a half-life write");

    a_e_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cdss_pkg::ST_TXE |-> e_reg <= 33'h1_0000_0000)
        else $error("decay factor above one");

    a_load_state: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req_data.operation == cdss_pkg::OP_LOAD |=>
            cur_pos_reg == $past(req_data.load_position) &&
            cur_vel_reg == $past(req_data.load_velocity))
        else $error("load beat did not set the state");

endmodule
